/* sv/tlms_pkg.sv */
// shared types and constants for the tail light mode sequencer
`default_nettype none

package tlms_pkg;

  localparam int TICK_W = 16;
  localparam int NBTN   = 4;

  localparam logic [2:0] MODE_DARK   = 3'd0;
  localparam logic [2:0] MODE_LEFT   = 3'd1;
  localparam logic [2:0] MODE_RIGHT  = 3'd2;
  localparam logic [2:0] MODE_STOP   = 3'd3;
  localparam logic [2:0] MODE_HAZARD = 3'd4;

  localparam logic [1:0] BTN_RIGHT  = 2'd0;
  localparam logic [1:0] BTN_BRAKE  = 2'd1;
  localparam logic [1:0] BTN_LEFT   = 2'd2;
  localparam logic [1:0] BTN_HAZARD = 2'd3;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_STEP     = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;
  localparam logic [1:0] REG_FLASH    = 2'd3;

  localparam logic [7:0]        DEBOUNCE_RST = 8'd50;
  localparam logic [TICK_W-1:0] STEP_RST     = 16'd200;
  localparam logic [TICK_W-1:0] TIMEOUT_RST  = 16'd5000;
  localparam logic [TICK_W-1:0] FLASH_RST    = 16'd1000;

  localparam logic [7:0] LAMPS_ALL    = 8'hFF;
  localparam logic [7:0] LAMPS_OUTER  = 8'h81;
  localparam logic [7:0] LAMPS_NONE   = 8'h00;
  localparam logic [3:0] TURN_STEPS   = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_APPLY,
    ST_PUSH
  } seq_state_t;

  typedef struct packed {
    logic done;
    logic zero;
  } mod_res_t;

endpackage

`default_nettype wire

/* sv/tlms_modu.sv */
// serial restoring remainder unit, one quotient bit per cycle
`default_nettype none

module tlms_modu (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [tlms_pkg::TICK_W-1:0] dividend,
  input  wire logic [tlms_pkg::TICK_W-1:0] divisor,
  output tlms_pkg::mod_res_t              res
);
  import tlms_pkg::*;

  localparam int CNT_W = $clog2(TICK_W);

  logic [TICK_W-1:0] rem_r, rem_nxt;
  logic [TICK_W-1:0] dvd_r, dvd_nxt;
  logic [TICK_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [TICK_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[TICK_W-1]};
    if (start) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = TICK_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[TICK_W-1:0];
      end
      dvd_nxt = {dvd_r[TICK_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(TICK_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign res.done = done_r;
  assign res.zero = (rem_r == '0);

endmodule

`default_nettype wire

/* sv/tail_light_mode_sequencer.sv */
// top level of the tail light mode sequencer
// usage:
//   input channel (in_valid/in_ready) carries one 1 ms tick with four
//   active-low button levels; output channel (out_valid/out_ready) returns
//   one result per tick: the eight lamp bits and the current mode.
//   cfg_we/cfg_idx/cfg_wdata write debounce_ticks, step_interval, turn_timeout and
//   flash_interval; the user must write them only while the block is idle; the block does not enforce this.
// sequence:
//   after a transfer the four buttons are scanned one per cycle, then a
//   16-step serial remainder unit checks the tick count against the step or
//   flash interval; the result is then written to the output register, and a
//   new tick is taken only after that, once the block is back in idle.
// reset and stalls:
//   rst_n (synchronous) clears mode, lamps, tick count and all debounce
//   state and loads the register defaults 50, 200, 5000 and 1000.
//   a result waiting on out_ready sits in the output register; the next
//   tick is still taken and processed, and its result waits until the
//   output register frees up.
`default_nettype none

module tail_light_mode_sequencer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_right_btn_n,
  input  wire logic                        in_brake_btn_n,
  input  wire logic                        in_left_btn_n,
  input  wire logic                        in_hazard_btn_n,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       out_lamps,
  output logic [2:0]                       out_mode_now,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_idx,
  input  wire logic [tlms_pkg::TICK_W-1:0] cfg_wdata
);
  import tlms_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [7:0]        dbt_r;
  logic [TICK_W-1:0] step_int_r;
  logic [TICK_W-1:0] timeout_r;
  logic [TICK_W-1:0] flash_int_r;

  logic [2:0]        mode_r, mode_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [7:0]        lamp_r, lamp_nxt;
  logic [3:0]        step_r, step_nxt;
  logic              phase_r, phase_nxt;
  logic              haz_on_r, haz_on_nxt;
  logic              turn_on_r, turn_on_nxt;
  logic [7:0]        dbc_r [NBTN];
  logic [7:0]        dbc_nxt [NBTN];
  logic [NBTN-1:0]   conf_r, conf_nxt;
  logic [NBTN-1:0]   btn_r, btn_nxt;
  logic [1:0]        idx_r, idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_lamps_r, out_lamps_nxt;
  logic [2:0]        out_mode_r, out_mode_nxt;

  logic              div_start;
  logic [TICK_W-1:0] div_every;
  mod_res_t          mod_res;

  tlms_modu u_modu (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tick_r),
    .divisor  (div_every),
    .res      (mod_res)
  );

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_lamps    = out_lamps_r;
  assign out_mode_now = out_mode_r;
  assign div_start    = (state_r == ST_DIV_GO);
  assign div_every    = (mode_r == MODE_HAZARD) ? flash_int_r : step_int_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbt_r       <= DEBOUNCE_RST;
      step_int_r  <= STEP_RST;
      timeout_r   <= TIMEOUT_RST;
      flash_int_r <= FLASH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DEBOUNCE: dbt_r       <= cfg_wdata[7:0];
        REG_STEP:     step_int_r  <= cfg_wdata;
        REG_TIMEOUT:  timeout_r   <= cfg_wdata;
        REG_FLASH:    flash_int_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic       pressed;
    logic [7:0] cnt;
    logic [7:0] cnt_inc;
    logic [7:0] cnt_dec;
    logic [2:0] bitn;
    logic       hit;
    logic [7:0] lamp_t;
    logic [2:0] mode_t;

    state_nxt     = state_r;
    mode_nxt      = mode_r;
    tick_nxt      = tick_r;
    lamp_nxt      = lamp_r;
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    haz_on_nxt    = haz_on_r;
    turn_on_nxt   = turn_on_r;
    dbc_nxt       = dbc_r;
    conf_nxt      = conf_r;
    btn_nxt       = btn_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_lamps_nxt = out_lamps_r;
    out_mode_nxt  = out_mode_r;

    pressed = !btn_r[idx_r];
    cnt     = dbc_r[idx_r];
    cnt_inc = cnt + 8'd1;
    cnt_dec = cnt - 8'd1;
    bitn    = (mode_r == MODE_RIGHT) ? (3'd7 - step_r[2:0]) : step_r[2:0];
    hit     = (div_every != '0) && (tick_r != '0) && mod_res.zero;
    lamp_t  = lamp_r;
    mode_t  = mode_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          tick_nxt  = tick_r + 1'b1;
          btn_nxt   = {in_hazard_btn_n, in_left_btn_n, in_brake_btn_n, in_right_btn_n};
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pressed) begin
          if (cnt < dbt_r) begin
            dbc_nxt[idx_r] = cnt_inc;
            if (cnt_inc == dbt_r && !conf_r[idx_r]) begin
              conf_nxt[idx_r] = 1'b1;
              case (idx_r)
                BTN_RIGHT, BTN_LEFT: begin
                  mode_t = (idx_r == BTN_RIGHT) ? MODE_RIGHT : MODE_LEFT;
                  if (mode_r != mode_t) begin
                    mode_nxt    = mode_t;
                    step_nxt    = '0;
                    lamp_nxt    = LAMPS_ALL;
                    turn_on_nxt = 1'b1;
                    tick_nxt    = '0;
                  end
                end
                BTN_BRAKE: begin
                  mode_nxt = MODE_STOP;
                  lamp_nxt = LAMPS_ALL;
                end
                BTN_HAZARD: begin
                  if (mode_r != MODE_HAZARD) begin
                    mode_nxt   = MODE_HAZARD;
                    phase_nxt  = 1'b1;
                    haz_on_nxt = 1'b1;
                    lamp_nxt   = LAMPS_OUTER;
                    tick_nxt   = '0;
                  end else if (haz_on_r) begin
                    haz_on_nxt = 1'b0;
                    mode_nxt   = MODE_DARK;
                    lamp_nxt   = LAMPS_NONE;
                  end else begin
                    haz_on_nxt = 1'b1;
                    lamp_nxt   = LAMPS_OUTER;
                  end
                end
                default: ;
              endcase
            end
          end
        end else if (cnt != 8'd0) begin
          dbc_nxt[idx_r] = cnt_dec;
          if (cnt_dec == 8'd0) begin
            conf_nxt[idx_r] = 1'b0;
            if (idx_r == BTN_BRAKE && mode_r == MODE_STOP) begin
              mode_nxt = MODE_DARK;
              lamp_nxt = LAMPS_NONE;
            end
          end
        end
        if (idx_r == BTN_HAZARD) begin
          state_nxt = ST_DIV_GO;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (mod_res.done) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        case (mode_r)
          MODE_LEFT, MODE_RIGHT: begin
            if (hit) begin
              if (step_r < TURN_STEPS) begin
                lamp_t   = lamp_r & ~(8'd1 << bitn);
                step_nxt = step_r + 4'd1;
              end else begin
                lamp_t   = LAMPS_ALL;
                step_nxt = '0;
              end
            end
            if (tick_r >= timeout_r && turn_on_r) begin
              turn_on_nxt = 1'b0;
              mode_t      = MODE_DARK;
              lamp_t      = LAMPS_NONE;
            end
          end
          MODE_HAZARD: begin
            if (haz_on_r) begin
              if (hit) begin
                lamp_t    = phase_r ? LAMPS_OUTER : LAMPS_NONE;
                phase_nxt = !phase_r;
              end
            end else begin
              lamp_t = LAMPS_NONE;
            end
          end
          MODE_DARK: lamp_t = LAMPS_NONE;
          default: ;
        endcase
        lamp_nxt  = lamp_t;
        mode_nxt  = mode_t;
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_lamps_nxt = lamp_r;
          out_mode_nxt  = mode_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_DARK;
      tick_r      <= '0;
      lamp_r      <= LAMPS_NONE;
      step_r      <= '0;
      phase_r     <= 1'b0;
      haz_on_r    <= 1'b0;
      turn_on_r   <= 1'b0;
      conf_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NBTN; i++) begin
        dbc_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      tick_r      <= tick_nxt;
      lamp_r      <= lamp_nxt;
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      haz_on_r    <= haz_on_nxt;
      turn_on_r   <= turn_on_nxt;
      conf_r      <= conf_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      dbc_r       <= dbc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    btn_r       <= btn_nxt;
    out_lamps_r <= out_lamps_nxt;
    out_mode_r  <= out_mode_nxt;
  end

endmodule

`default_nettype wire

/* tb/tb_tail_light_mode_sequencer.sv */
// testbench for the tail light mode sequencer: every tick result is checked against a local model
module tb_tail_light_mode_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import tlms_pkg::*;

  typedef struct packed {
    logic [7:0] lamps;
    logic [2:0] mode;
  } light_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_right_btn_n = 1'b1;
  logic in_brake_btn_n = 1'b1;
  logic in_left_btn_n = 1'b1;
  logic in_hazard_btn_n = 1'b1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_lamps;
  logic [2:0] out_mode_now;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = REG_DEBOUNCE;
  logic [TICK_W-1:0] cfg_wdata = '0;

  tail_light_mode_sequencer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_right_btn_n (in_right_btn_n),
    .in_brake_btn_n (in_brake_btn_n),
    .in_left_btn_n  (in_left_btn_n),
    .in_hazard_btn_n(in_hazard_btn_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_lamps      (out_lamps),
    .out_mode_now   (out_mode_now),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata)
  );

  // model copy of registers and state
  logic [7:0]        hold_ticks;
  logic [TICK_W-1:0] step_every;
  logic [TICK_W-1:0] turn_limit;
  logic [TICK_W-1:0] flash_every;
  logic [2:0]        mode_q;
  logic [TICK_W-1:0] ticks_q;
  logic [7:0]        lamps_q;
  logic [3:0]        step_q;
  logic              phase_q;
  logic              hazard_q;
  logic              turn_q;
  logic [7:0]        db_cnt [NBTN];
  logic              db_held [NBTN];

  light_res_t pending_lights[$];
  int fail_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic [3:0] btn_lvl = 4'hF;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    light_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lights.size() == 0) begin
        $display("%0t: unexpected transfer lamps=%h mode=%0d", $time, out_lamps, out_mode_now);
        fail_count++;
      end else begin
        want = pending_lights.pop_front();
        if (out_lamps !== want.lamps) begin
          $display("%0t: lamps expected %h actual %h", $time, want.lamps, out_lamps);
          fail_count++;
        end
        if (out_mode_now !== want.mode) begin
          $display("%0t: mode expected %0d actual %0d", $time, want.mode, out_mode_now);
          fail_count++;
        end
      end
    end
  end

  function automatic void clear_model();
    hold_ticks = DEBOUNCE_RST;
    step_every = STEP_RST;
    turn_limit = TIMEOUT_RST;
    flash_every = FLASH_RST;
    mode_q = MODE_DARK;
    ticks_q = '0;
    lamps_q = LAMPS_NONE;
    step_q = '0;
    phase_q = 1'b0;
    hazard_q = 1'b0;
    turn_q = 1'b0;
    for (int b = 0; b < NBTN; b++) begin
      db_cnt[b] = '0;
      db_held[b] = 1'b0;
    end
  endfunction

  function automatic bit at_interval(logic [TICK_W-1:0] every);
    return every != 0 && ticks_q != 0 && (ticks_q % every) == 0;
  endfunction

  function automatic void enter_turn(logic [2:0] m);
    if (mode_q != m) begin
      mode_q = m;
      step_q = '0;
      lamps_q = LAMPS_ALL;
      turn_q = 1'b1;
      ticks_q = '0;
    end
  endfunction

  function automatic void confirm_press(logic [1:0] b);
    case (b)
      BTN_RIGHT: enter_turn(MODE_RIGHT);
      BTN_BRAKE: begin
        mode_q = MODE_STOP;
        lamps_q = LAMPS_ALL;
      end
      BTN_LEFT: enter_turn(MODE_LEFT);
      default: begin
        if (mode_q != MODE_HAZARD) begin
          mode_q = MODE_HAZARD;
          phase_q = 1'b1;
          hazard_q = 1'b1;
          lamps_q = LAMPS_OUTER;
          ticks_q = '0;
        end else if (hazard_q) begin
          hazard_q = 1'b0;
          mode_q = MODE_DARK;
          lamps_q = LAMPS_NONE;
        end else begin
          hazard_q = 1'b1;
          lamps_q = LAMPS_OUTER;
        end
      end
    endcase
  endfunction

  function automatic void advance_turn(bit right);
    logic [2:0] pos;
    if (at_interval(step_every)) begin
      if (step_q < TURN_STEPS) begin
        pos = right ? 3'd7 - step_q[2:0] : step_q[2:0];
        lamps_q[pos] = 1'b0;
        step_q++;
      end else begin
        step_q = '0;
        lamps_q = LAMPS_ALL;
      end
    end
    if (ticks_q >= turn_limit && turn_q) begin
      turn_q = 1'b0;
      mode_q = MODE_DARK;
      lamps_q = LAMPS_NONE;
    end
  endfunction

  function automatic light_res_t predict_tick(logic [3:0] btn_n);
    ticks_q++;
    for (int b = 0; b < NBTN; b++) begin
      if (!btn_n[b]) begin
        if (db_cnt[b] < hold_ticks) begin
          db_cnt[b]++;
          if (db_cnt[b] == hold_ticks && !db_held[b]) begin
            db_held[b] = 1'b1;
            confirm_press(2'(b));
          end
        end
      end else if (db_cnt[b] != 0) begin
        db_cnt[b]--;
        if (db_cnt[b] == 0) begin
          db_held[b] = 1'b0;
          if (2'(b) == BTN_BRAKE && mode_q == MODE_STOP) begin
            mode_q = MODE_DARK;
            lamps_q = LAMPS_NONE;
          end
        end
      end
    end
    case (mode_q)
      MODE_LEFT: advance_turn(1'b0);
      MODE_RIGHT: advance_turn(1'b1);
      MODE_HAZARD: begin
        if (hazard_q) begin
          if (at_interval(flash_every)) begin
            lamps_q = phase_q ? LAMPS_OUTER : LAMPS_NONE;
            phase_q = ~phase_q;
          end
        end else begin
          lamps_q = LAMPS_NONE;
        end
      end
      MODE_DARK: lamps_q = LAMPS_NONE;
      default: ;
    endcase
    return '{lamps: lamps_q, mode: mode_q};
  endfunction

  function automatic void set_pacing(int k);
    case (k % 4)
      0: begin idle_pct = 0; stall_pct = 0; end
      1: begin idle_pct = 70; stall_pct = 0; end
      2: begin idle_pct = 0; stall_pct = 70; end
      default: begin idle_pct = 11; stall_pct = 11; end
    endcase
  endfunction

  task automatic send_tick(input logic [3:0] btn_n);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_hazard_btn_n, in_left_btn_n, in_brake_btn_n, in_right_btn_n} <= btn_n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_lights.push_back(predict_tick(btn_n));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_lights.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] d, input logic [TICK_W-1:0] s,
                            input logic [TICK_W-1:0] t, input logic [TICK_W-1:0] f);
    logic [1:0] idx [4] = '{REG_DEBOUNCE, REG_STEP, REG_TIMEOUT, REG_FLASH};
    logic [TICK_W-1:0] val [4];
    val = '{TICK_W'(d), s, t, f};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    hold_ticks = d;
    step_every = s;
    turn_limit = t;
    flash_every = f;
  endtask

  task automatic run_random(input int count, input logic [3:0] mask, input int flip_pct,
                            input int press_pct);
    int offs;
    offs = $urandom_range(3);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) set_pacing(i / 40 + offs);
      for (int b = 0; b < NBTN; b++) begin
        if (!mask[b]) btn_lvl[b] = 1'b1;
        else if ($urandom_range(99) < flip_pct)
          btn_lvl[b] = ($urandom_range(99) < press_pct) ? 1'b0 : 1'b1;
      end
      send_tick(btn_lvl);
    end
  endtask

  task automatic test_reset_defaults();
    set_pacing(0);
    repeat (60) send_tick(4'b1101);
    repeat (5) send_tick(4'b1111);
  endtask

  task automatic test_directed();
    logic [3:0] seq [$];
    seq = {4'b1111, 4'b0000, 4'b1111, 4'b1011};
    repeat (9) seq.push_back(4'b1011);
    // re-press of the active turn, then right, brake and hazard toggling
    seq = {seq, 4'b1111, 4'b1011, 4'b1110, 4'b1111, 4'b1101, 4'b1111,
           4'b0111, 4'b1111, 4'b1111, 4'b1111, 4'b0111};
    set_config(8'd1, 16'd1, 16'd12, 16'd2);
    set_pacing(0);
    foreach (seq[i]) send_tick(seq[i]);
  endtask

  task automatic test_turn_signals();
    set_config(8'($urandom_range(1, 4)), 16'($urandom_range(1, 6)),
               16'($urandom_range(10, 80)), 16'($urandom_range(1, 6)));
    run_random(125, 4'b0101, 12, 60);
    set_config(8'($urandom_range(1, 4)), 16'($urandom_range(1, 6)),
               16'($urandom_range(10, 80)), 16'($urandom_range(1, 6)));
    run_random(125, 4'b0111, 12, 60);
  endtask

  task automatic test_hazard_flash();
    set_config(8'($urandom_range(1, 3)), 16'($urandom_range(1, 6)),
               16'($urandom_range(10, 80)), 16'($urandom_range(1, 6)));
    run_random(100, 4'b1000, 10, 50);
    set_config(8'($urandom_range(1, 3)), 16'($urandom_range(1, 6)),
               16'($urandom_range(10, 80)), 16'($urandom_range(1, 6)));
    run_random(100, 4'b1101, 10, 50);
  endtask

  task automatic test_brake_lights();
    set_config(8'($urandom_range(1, 4)), 16'($urandom_range(1, 6)),
               16'($urandom_range(10, 80)), 16'($urandom_range(1, 6)));
    run_random(75, 4'b0010, 15, 50);
    run_random(75, 4'b1011, 15, 50);
  endtask

  task automatic test_config_extremes();
    set_config(8'd255, 16'd1, 16'hFFFF, 16'd1);
    set_pacing(3);
    repeat (260) send_tick(4'b1011);
    repeat (10) send_tick(4'b1111);
    set_config(8'd1, 16'hFFFF, 16'd1, 16'hFFFF);
    run_random(80, 4'b1111, 15, 50);
    set_config(8'd2, 16'd1, 16'hFFFF, 16'd1);
    run_random(80, 4'b1111, 15, 50);
    set_config(8'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(80, 4'b1111, 15, 50);
  endtask

  task automatic test_random_mix();
    for (int p = 0; p < 5; p++) begin
      set_config(8'($urandom_range(1, 6)), 16'($urandom_range(1, 8)),
                 16'($urandom_range(5, 120)), 16'($urandom_range(1, 6)));
      run_random(50, 4'b1111, 15, 60);
    end
  endtask

  initial begin
    clear_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_turn_signals();
    test_hazard_flash();
    test_brake_lights();
    test_config_extremes();
    test_random_mix();
    wait_idle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
